// ===== rtl/pwr_pkg.sv =====
// shared constants and types for the particle wall reflection pipeline
package pwr_pkg;

    // value format and derived widths
    localparam int VALUE_WIDTH = 32;
    localparam int QW          = VALUE_WIDTH + 1;      // capped quotient width
    localparam int PW          = 2 * VALUE_WIDTH + 1;  // product width
    localparam int SW          = QW + 2;               // saturating sum width
    localparam int HALF_W      = 32;
    localparam int BOUND_W     = 64;
    localparam int NUM_FACES   = 6;
    localparam int CFG_IDX_W   = 3;

    localparam logic [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_MODE    = 3'd0,
        REG_VEL_MODE    = 3'd1,
        REG_FORCE_MODE  = 3'd2,
        REG_SPACE_DIMS  = 3'd3,
        REG_WALL_ENABLE = 3'd4,
        REG_X_BOUNDS    = 3'd5,
        REG_Y_BOUNDS    = 3'd6,
        REG_Z_BOUNDS    = 3'd7
    } reg_idx_t;

    // position modes
    typedef enum logic [1:0] {
        POS_NONE    = 2'd0,
        POS_MIRROR  = 2'd1,
        POS_INVERSE = 2'd2
    } pos_mode_t;

    // velocity and force modes
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_NORMAL = 2'd1,
        ACT_ALL    = 2'd2
    } act_mode_t;

    localparam logic [1:0] DIMS_TWO = 2'd2;

    // configuration seen by every face
    typedef struct packed {
        logic [1:0]                  pos_mode;
        logic [1:0]                  vel_mode;
        logic [1:0]                  force_mode;
        logic                        dims3;
        logic [NUM_FACES-1:0]        wall_enable;
        logic [2:0][BOUND_W-1:0]     bounds;
    } cfg_t;

    // one particle as it travels down the pipeline
    typedef struct packed {
        logic [2:0][VALUE_WIDTH-1:0] p;
        logic [2:0][VALUE_WIDTH-1:0] o;
        logic [2:0][VALUE_WIDTH-1:0] v;
        logic [2:0][VALUE_WIDTH-1:0] f;
        logic [NUM_FACES-1:0]        hits;
        logic                        fault;
    } particle_t;

endpackage

// ===== rtl/pwr_face.sv =====
// one box face: hit test, mirror, negation and pipelined inverse interpolation
module pwr_face (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [2:0]        face,
    input  pwr_pkg::cfg_t     cfg,
    input  logic              in_vld,
    input  pwr_pkg::particle_t in_part,
    output logic              out_vld,
    output pwr_pkg::particle_t out_part
);
    import pwr_pkg::*;

    localparam int VW = VALUE_WIDTH;
    localparam int WW = (VW > HALF_W) ? VW : HALF_W;
    localparam logic signed [SW-1:0] S_MAX = SW'(VMAX);
    localparam logic signed [SW-1:0] S_MIN = SW'(-S_MAX - 1);
    localparam logic signed [WW-1:0] W_MAX = WW'(VMAX);
    localparam logic signed [WW-1:0] W_MIN = WW'(-W_MAX - 1);

    typedef struct packed {
        particle_t            part;
        logic [VW-1:0]        c;
        logic                 hit;
        logic                 cneg;
        logic [VW-1:0]        m;
        logic [VW-1:0]        den;
        logic                 dneg;
        logic [1:0][VW-1:0]   sm;
        logic [1:0]           sneg;
        logic [1:0]           use_t;
    } s1_t;

    typedef struct packed {
        particle_t            part;
        logic                 act;
        logic [1:0]           sgn;
        logic [1:0]           use_t;
        logic [VW-1:0]        den;
        logic [1:0][PW-1:0]   prod;
    } s2_t;

    typedef struct packed {
        particle_t            part;
        logic                 act;
        logic [1:0]           sgn;
        logic [1:0]           use_t;
        logic [1:0]           sat;
        logic [VW-1:0]        den;
        logic [1:0][VW-1:0]   rem;
        logic [1:0][QW-1:0]   low;
        logic [1:0][QW-1:0]   quo;
    } dv_t;

    // tangential coordinate k of normal axis dd
    function automatic logic [1:0] tan_idx(input logic [1:0] dd, input logic k);
        logic [1:0] r;
        case (dd)
            2'd0:    r = k ? 2'd2 : 2'd1;
            2'd1:    r = k ? 2'd0 : 2'd2;
            default: r = k ? 2'd1 : 2'd0;
        endcase
        return r;
    endfunction

    // {a < b, |a - b|}
    function automatic logic [VW:0] mag_diff(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic signed [VW:0] df;
        logic signed [VW:0] nd;
        df = $signed({a[VW-1], a}) - $signed({b[VW-1], b});
        nd = -df;
        return df[VW] ? {1'b1, nd[VW-1:0]} : {1'b0, df[VW-1:0]};
    endfunction

    // base plus or minus a magnitude, saturated to the value range
    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] base, input logic neg,
                                              input logic [QW-1:0] mg);
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] mx;
        s  = SW'($signed(base));
        mx = $signed(SW'(mg));
        s  = neg ? (s - mx) : (s + mx);
        if (s > S_MAX)
            return VMAX;
        else if (s < S_MIN)
            return VMIN;
        return s[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] neg_sat(input logic [VW-1:0] x);
        return (x == VMIN) ? VMAX : VW'(-x);
    endfunction

    // wall half clamped into the value range
    function automatic logic [VW-1:0] clamp_wall(input logic [HALF_W-1:0] h);
        logic signed [WW-1:0] hx;
        hx = WW'($signed(h));
        if (hx > W_MAX)
            return VMAX;
        else if (hx < W_MIN)
            return VMIN;
        return hx[VW-1:0];
    endfunction

    // one restoring division step on both tangential lanes
    function automatic dv_t div_step(input dv_t x);
        dv_t          y;
        logic [VW:0]  rs;
        y = x;
        for (int k = 0; k < 2; k++) begin
            rs = {x.rem[k], x.low[k][QW-1]};
            if (rs >= {1'b0, x.den}) begin
                rs       = rs - {1'b0, x.den};
                y.quo[k] = {x.quo[k][QW-2:0], 1'b1};
            end
            else begin
                y.quo[k] = {x.quo[k][QW-2:0], 1'b0};
            end
            y.rem[k] = rs[VW-1:0];
            y.low[k] = {x.low[k][QW-2:0], 1'b0};
        end
        return y;
    endfunction

    logic [1:0]     d;
    logic           upper;
    logic [1:0]     tix0;
    logic [1:0]     tix1;

    assign d     = face[2:1];
    assign upper = face[0];
    assign tix0  = tan_idx(d, 1'b0);
    assign tix1  = tan_idx(d, 1'b1);

    s1_t  s1_next, s1_reg;
    s2_t  s2_next, s2_reg;
    dv_t  dv_init;
    dv_t  dv_reg [0:QW];
    particle_t out_next, out_reg;
    logic s1_vld_reg, s2_vld_reg, out_vld_reg;
    logic [QW:0] dv_vld_reg;

    // hit test and distances
    always_comb
    begin
        logic [VW:0]   md;
        logic [VW-1:0] pd;
        logic [1:0]    tj;
        s1_next      = '0;
        s1_next.part = in_part;
        pd           = in_part.p[d];
        s1_next.c    = clamp_wall(upper ? cfg.bounds[d][BOUND_W-1:HALF_W]
                                        : cfg.bounds[d][HALF_W-1:0]);
        s1_next.hit  = cfg.wall_enable[face] && (d != 2'd2 || cfg.dims3) &&
                       (upper ? ($signed(pd) > $signed(s1_next.c))
                              : ($signed(pd) < $signed(s1_next.c)));
        md           = mag_diff(s1_next.c, pd);
        s1_next.cneg = md[VW];
        s1_next.m    = md[VW-1:0];
        md           = mag_diff(in_part.o[d], pd);
        s1_next.dneg = md[VW];
        s1_next.den  = md[VW-1:0];
        for (int k = 0; k < 2; k++) begin
            tj                = (k == 0) ? tix0 : tix1;
            md                = mag_diff(in_part.o[tj], in_part.p[tj]);
            s1_next.sneg[k]   = md[VW];
            s1_next.sm[k]     = md[VW-1:0];
            s1_next.use_t[k]  = (tj != 2'd2) || cfg.dims3;
        end
    end

    // mirror, negations and products
    always_comb
    begin
        logic [VW:0] travel;
        s2_next      = '0;
        s2_next.part = s1_reg.part;
        if (s1_reg.hit) begin
            s2_next.part.hits[face] = 1'b1;
            if (cfg.pos_mode == POS_MIRROR || cfg.pos_mode == POS_INVERSE)
                s2_next.part.p[d] = sat_add(s1_reg.c, s1_reg.cneg, QW'(s1_reg.m));
            if (cfg.pos_mode == POS_INVERSE && s1_reg.den == '0)
                s2_next.part.fault = 1'b1;
            case (cfg.vel_mode)
                ACT_NORMAL: s2_next.part.v[d] = neg_sat(s1_reg.part.v[d]);
                ACT_ALL:
                begin
                    for (int j = 0; j < 3; j++)
                        if (j != 2 || cfg.dims3)
                            s2_next.part.v[j] = neg_sat(s1_reg.part.v[j]);
                end
                default: ;
            endcase
            case (cfg.force_mode)
                ACT_NORMAL: s2_next.part.f[d] = neg_sat(s1_reg.part.f[d]);
                ACT_ALL:
                begin
                    for (int j = 0; j < 3; j++)
                        if (j != 2 || cfg.dims3)
                            s2_next.part.f[j] = neg_sat(s1_reg.part.f[j]);
                end
                default: ;
            endcase
        end
        s2_next.act   = s1_reg.hit && cfg.pos_mode == POS_INVERSE && s1_reg.den != '0;
        s2_next.sgn   = s1_reg.sneg ^ {2{s1_reg.cneg ^ s1_reg.dneg}};
        s2_next.use_t = s1_reg.use_t;
        s2_next.den   = s1_reg.den;
        travel        = {s1_reg.m, 1'b0};
        for (int k = 0; k < 2; k++)
            s2_next.prod[k] = PW'(s1_reg.sm[k]) * PW'(travel);
    end

    // divider setup, quotients at or above the cap saturate
    always_comb
    begin
        dv_init       = '0;
        dv_init.part  = s2_reg.part;
        dv_init.act   = s2_reg.act;
        dv_init.sgn   = s2_reg.sgn;
        dv_init.use_t = s2_reg.use_t;
        dv_init.den   = s2_reg.den;
        for (int k = 0; k < 2; k++) begin
            dv_init.sat[k] = s2_reg.prod[k][PW-1:QW] >= s2_reg.den;
            dv_init.rem[k] = s2_reg.prod[k][PW-1:QW];
            dv_init.low[k] = s2_reg.prod[k][QW-1:0];
        end
    end

    // tangential moves back along the path
    always_comb
    begin
        logic [QW-1:0] qm;
        out_next = dv_reg[QW].part;
        for (int k = 0; k < 2; k++) begin
            qm = dv_reg[QW].sat[k] ? {QW{1'b1}} : dv_reg[QW].quo[k];
            if (dv_reg[QW].act && dv_reg[QW].use_t[k]) begin
                if (k == 0)
                    out_next.p[tix0] = sat_add(dv_reg[QW].part.p[tix0], dv_reg[QW].sgn[k], qm);
                else
                    out_next.p[tix1] = sat_add(dv_reg[QW].part.p[tix1], dv_reg[QW].sgn[k], qm);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            dv_vld_reg  <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv) begin
            s1_vld_reg  <= in_vld;
            s2_vld_reg  <= s1_vld_reg;
            dv_vld_reg  <= {dv_vld_reg[QW-1:0], s2_vld_reg};
            out_vld_reg <= dv_vld_reg[QW];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            dv_reg[0] <= dv_init;
            for (int i = 1; i <= QW; i++)
                dv_reg[i] <= div_step(dv_reg[i-1]);
            out_reg   <= out_next;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_part = out_reg;

    a_act_den: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg && s2_reg.act |-> s2_reg.den != '0)
        else $error("inverse move scheduled with zero divisor");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_vld_reg[QW] && dv_reg[QW].act && !dv_reg[QW].sat[0] |->
        dv_reg[QW].rem[0] < dv_reg[QW].den)
        else $error("division remainder not below divisor");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv && out_vld_reg |=> out_vld_reg && $stable(out_reg))
        else $error("face result changed while pipeline held");

endmodule

// ===== rtl/particle_wall_reflect.sv =====
// particle wall reflection: configuration registers and six-face pipeline
// Takes one particle per clock while not stalled and returns one result per particle in
// order. Each of the six faces is a pipeline section of VALUE_WIDTH+5 stages (hit test,
// mirror and products, divider setup, a VALUE_WIDTH+1 step restoring divider for the
// inverse move, final sum). The divider is always in the path, so latency does not
// depend on mode. A stalled result holds the whole pipeline; in_stall follows
// out_stall while a result waits.
// Configuration writes are always ready and must only occur while the block is empty.
module particle_wall_reflect (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pwr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pwr_pkg::BOUND_W-1:0]            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] pos_x,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] pos_y,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] pos_z,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] old_pos_x,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] old_pos_y,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] old_pos_z,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] vel_x,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] vel_y,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] vel_z,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] force_x,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] force_y,
    input  logic signed [pwr_pkg::VALUE_WIDTH-1:0] force_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pwr_pkg::VALUE_WIDTH-1:0] new_pos_x,
    output logic signed [pwr_pkg::VALUE_WIDTH-1:0] new_pos_y,
    output logic signed [pwr_pkg::VALUE_WIDTH-1:0] new_pos_z,
    output logic signed [pwr_pkg::VALUE_WIDTH-1:0] new_vel_x,
    output logic signed [pwr_pkg::VALUE_WIDTH-1:0] new_vel_y,
    output logic signed [pwr_pkg::VALUE_WIDTH-1:0] new_vel_z,
    output logic signed [pwr_pkg::VALUE_WIDTH-1:0] new_force_x,
    output logic signed [pwr_pkg::VALUE_WIDTH-1:0] new_force_y,
    output logic signed [pwr_pkg::VALUE_WIDTH-1:0] new_force_z,
    output logic [pwr_pkg::NUM_FACES-1:0]          hit_faces,
    output logic                                   divide_fault
);
    import pwr_pkg::*;

    logic [1:0]              pos_mode_reg, vel_mode_reg, force_mode_reg, space_dims_reg;
    logic [NUM_FACES-1:0]    wall_enable_reg;
    logic [2:0][BOUND_W-1:0] bounds_reg;
    cfg_t                    cfg;
    logic                    adv;
    logic [NUM_FACES:0]      f_vld;
    particle_t               f_part [0:NUM_FACES];

    // configuration write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_mode_reg    <= POS_MIRROR;
            vel_mode_reg    <= ACT_NORMAL;
            force_mode_reg  <= ACT_NONE;
            space_dims_reg  <= 2'd3;
            wall_enable_reg <= '0;
            bounds_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_POS_MODE:    pos_mode_reg    <= cfg_data[1:0];
                REG_VEL_MODE:    vel_mode_reg    <= cfg_data[1:0];
                REG_FORCE_MODE:  force_mode_reg  <= cfg_data[1:0];
                REG_SPACE_DIMS:  space_dims_reg  <= cfg_data[1:0];
                REG_WALL_ENABLE: wall_enable_reg <= cfg_data[NUM_FACES-1:0];
                REG_X_BOUNDS:    bounds_reg[0]   <= cfg_data;
                REG_Y_BOUNDS:    bounds_reg[1]   <= cfg_data;
                REG_Z_BOUNDS:    bounds_reg[2]   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg.pos_mode    = pos_mode_reg;
        cfg.vel_mode    = vel_mode_reg;
        cfg.force_mode  = force_mode_reg;
        cfg.dims3       = space_dims_reg != DIMS_TWO;
        cfg.wall_enable = wall_enable_reg;
        cfg.bounds      = bounds_reg;
    end

    // whole pipeline moves unless the output holds a stalled result
    assign adv      = !(f_vld[NUM_FACES] && out_stall);
    assign in_stall = !adv;

    // input transaction into the first face
    assign f_vld[0] = in_valid;

    always_comb
    begin
        f_part[0]       = '0;
        f_part[0].p[0]  = pos_x;
        f_part[0].p[1]  = pos_y;
        f_part[0].p[2]  = pos_z;
        f_part[0].o[0]  = old_pos_x;
        f_part[0].o[1]  = old_pos_y;
        f_part[0].o[2]  = old_pos_z;
        f_part[0].v[0]  = vel_x;
        f_part[0].v[1]  = vel_y;
        f_part[0].v[2]  = vel_z;
        f_part[0].f[0]  = force_x;
        f_part[0].f[1]  = force_y;
        f_part[0].f[2]  = force_z;
    end

    // faces in order xlo, xhi, ylo, yhi, zlo, zhi
    for (genvar g = 0; g < NUM_FACES; g++) begin : g_face
        pwr_face u_face (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .face     (3'(g)),
            .cfg      (cfg),
            .in_vld   (f_vld[g]),
            .in_part  (f_part[g]),
            .out_vld  (f_vld[g+1]),
            .out_part (f_part[g+1])
        );
    end

    // result transaction
    assign out_valid    = f_vld[NUM_FACES];
    assign new_pos_x    = f_part[NUM_FACES].p[0];
    assign new_pos_y    = f_part[NUM_FACES].p[1];
    assign new_pos_z    = f_part[NUM_FACES].p[2];
    assign new_vel_x    = f_part[NUM_FACES].v[0];
    assign new_vel_y    = f_part[NUM_FACES].v[1];
    assign new_vel_z    = f_part[NUM_FACES].v[2];
    assign new_force_x  = f_part[NUM_FACES].f[0];
    assign new_force_y  = f_part[NUM_FACES].f[1];
    assign new_force_z  = f_part[NUM_FACES].f[2];
    assign hit_faces    = f_part[NUM_FACES].hits;
    assign divide_fault = f_part[NUM_FACES].fault;

endmodule
